/* rtl/tcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg - shared types and constants for the text console writer
// Character codes, mode codes, register map and the control state type.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [7:0] ATTR_RESET = 8'd7;

  // register word index (paddr[2])
  localparam logic REG_TEXT_ATTRIBUTE = 1'b0;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int CELL_W     = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_BLANK,
    ST_EMIT
  } state_t;

endpackage

/* rtl/tcw_screen_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_screen_ram - screen cell store
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_screen_ram
  import tcw_pkg::*;
#(
  parameter int DEPTH = COLUMNS_DEF * ROWS_DEF,
  parameter int AW    = $clog2(COLUMNS_DEF * ROWS_DEF)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/text_console_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer - character-cell text console
// Cursor logic around a ROWS x COLUMNS store of 16-bit cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per transaction: tuser = mode (put, clear,
//   read), tdata = char_code and cell_index. m_axis returns one result per
//   command: cell word, cursor row/column after the command, scroll flag.
//   The APB port holds the attribute byte used for written and blank cells.
// Sequence:
//   put, newline, backspace and unused mode: the result is loaded from the
//   emit state; the next command is taken once the block is back in idle.
//   Read: a registered store read in the read state, then the emit state.
//   Scroll: one read and one write per moved cell,
//   then one blank write per bottom-row cell, before the emit state.
//   Clear: one blank write per cell, then the emit state.
// Reset: cursor homes, attribute returns to 7, no result pending. Cell
//   contents are not cleared; software issues a clear before use.
// Stall: a finished result sits in the output register; the next command
//   is taken meanwhile, but its result waits until the register frees.
// ----------------------------------------------------------------------------
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // command stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] char_code, [18:8] cell_index
  input  logic [1:0]            s_axis_tuser,   // [1:0] mode
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [15:0] cell_word, [20:16] cursor_row, [27:21] cursor_col, [28] scrolled
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int RW         = $clog2(ROWS);
  localparam int CW         = $clog2(COLUMNS);
  localparam int SCROLL_END = COLUMNS * (ROWS - 1) - 1;

  // ---------------------------------------------------------------- config
  logic [7:0] text_attribute;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ATTR_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_TEXT_ATTRIBUTE) begin
      text_attribute <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_TEXT_ATTRIBUTE) ? 32'(text_attribute) : 32'd0;

  // ---------------------------------------------------------------- fields
  logic [1:0]  in_mode;
  logic [7:0]  in_char;
  logic [10:0] in_index;

  assign in_mode  = s_axis_tuser;
  assign in_char  = s_axis_tdata[7:0];
  assign in_index = s_axis_tdata[18:8];

  // ---------------------------------------------------------------- state
  state_t            state, state_next;
  logic [RW-1:0]     row, row_next;
  logic [CW-1:0]     col, col_next;
  logic [AW-1:0]     sweep, sweep_next;
  logic [CELL_W-1:0] res_word, res_word_next;
  logic              res_scrolled, res_scrolled_next;

  logic              out_valid;
  logic [OUT_DATA_W-1:0] out_data;
  logic              out_load;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  logic [AW-1:0]     cursor_addr;
  logic [CELL_W-1:0] blank_cell;
  logic              out_free;

  assign cursor_addr = AW'(AW'(row) * AW'(COLUMNS) + AW'(col));
  assign blank_cell  = {text_attribute, CH_SPACE};
  assign out_free    = !out_valid || m_axis_tready;

  tcw_screen_ram #(
    .DEPTH (CELL_COUNT),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      row   <= '0;
      col   <= '0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
    end
  end

  always_ff @(posedge clk) begin
    sweep        <= sweep_next;
    res_word     <= res_word_next;
    res_scrolled <= res_scrolled_next;
  end

  always_comb begin
    state_next        = state;
    row_next          = row;
    col_next          = col;
    sweep_next        = sweep;
    res_word_next     = res_word;
    res_scrolled_next = res_scrolled;
    ram_we            = 1'b0;
    ram_waddr         = cursor_addr;
    ram_wdata         = {text_attribute, in_char};
    ram_re            = 1'b0;
    ram_raddr         = AW'(in_index);
    out_load          = 1'b0;
    s_axis_tready     = (state == ST_IDLE);

    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          res_word_next     = '0;
          res_scrolled_next = 1'b0;
          sweep_next        = '0;
          state_next        = ST_EMIT;
          case (in_mode)
            MODE_PUT: begin
              // newline and printable at the last column share the line step
              if (in_char == CH_BACKSPACE) begin
                if (col != '0) begin
                  col_next = col - CW'(1);
                end else if (row != '0) begin
                  row_next = row - RW'(1);
                  col_next = CW'(COLUMNS - 1);
                end
              end else if (in_char != CH_NEWLINE && col != CW'(COLUMNS - 1)) begin
                ram_we   = 1'b1;
                col_next = col + CW'(1);
              end else begin
                ram_we   = (in_char != CH_NEWLINE);
                col_next = '0;
                if (row == RW'(ROWS - 1)) begin
                  res_scrolled_next = 1'b1;
                  state_next        = ST_SCROLL_RD;
                end else begin
                  row_next = row + RW'(1);
                end
              end
            end
            MODE_CLEAR: begin
              row_next   = '0;
              col_next   = '0;
              state_next = ST_BLANK;
            end
            MODE_READ: begin
              if (32'(in_index) < 32'(CELL_COUNT)) begin
                ram_re     = 1'b1;
                state_next = ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        res_word_next = ram_rdata;
        state_next    = ST_EMIT;
      end
      ST_SCROLL_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = AW'(sweep + AW'(COLUMNS));
        state_next = ST_SCROLL_WR;
      end
      ST_SCROLL_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = sweep;
        ram_wdata  = ram_rdata;
        sweep_next = sweep + AW'(1);
        // after the last moved cell, sweep lands on the start of the bottom row
        state_next = (sweep == AW'(SCROLL_END)) ? ST_BLANK : ST_SCROLL_RD;
      end
      ST_BLANK: begin
        ram_we     = 1'b1;
        ram_waddr  = sweep;
        ram_wdata  = blank_cell;
        sweep_next = sweep + AW'(1);
        if (sweep == AW'(CELL_COUNT - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= {3'd0, res_scrolled, 7'(col), 5'(row), res_word};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking testbench for text_console_writer
// Drives commands on the slave stream under several idle/stall mixes, keeps
// an own model of the screen and cursor, and checks every result
// transaction in order.
// ----------------------------------------------------------------------------
module tb;
  import tcw_pkg::*;

  localparam int CELL_COUNT = COLUMNS_DEF * ROWS_DEF;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_TEXT_ATTRIBUTE = {REG_TEXT_ATTRIBUTE, 2'b00};
  // allow every command to scroll, stalls included
  localparam longint CYCLE_LIMIT = 10_000_000;
  localparam int RANDOM_PER_PHASE = 110;

  typedef struct packed {
    logic        scrolled;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [15:0] cell_word;
  } console_result_t;

  class console_scoreboard;
    logic [15:0]     cells [CELL_COUNT];
    int unsigned     row;
    int unsigned     col;
    logic [7:0]      attribute;
    console_result_t pending[$];
    int unsigned     error_count;

    function new();
      foreach (cells[i]) cells[i] = '0;
      row = 0;
      col = 0;
      attribute = ATTR_RESET;
      error_count = 0;
    endfunction

    function void set_attribute(logic [7:0] value);
      attribute = value;
    endfunction

    function void blank_cells(int unsigned from);
      for (int unsigned i = from; i < CELL_COUNT; i++) cells[i] = {attribute, CH_SPACE};
    endfunction

    // returns 1 when the move ran off the bottom and the screen scrolled
    function bit advance_line();
      col = 0;
      row++;
      if (row >= ROWS_DEF) begin
        for (int unsigned i = 0; i < COLUMNS_DEF * (ROWS_DEF - 1); i++)
          cells[i] = cells[i + COLUMNS_DEF];
        blank_cells(COLUMNS_DEF * (ROWS_DEF - 1));
        row = ROWS_DEF - 1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_command(logic [1:0] mode, logic [7:0] ch, logic [10:0] idx);
      console_result_t res;
      res = '0;
      case (mode)
        MODE_PUT: begin
          if (ch == CH_NEWLINE) begin
            res.scrolled = advance_line();
          end else if (ch == CH_BACKSPACE) begin
            if (col > 0) begin
              col--;
            end else if (row > 0) begin
              row--;
              col = COLUMNS_DEF - 1;
            end
          end else begin
            cells[row * COLUMNS_DEF + col] = {attribute, ch};
            col++;
            if (col >= COLUMNS_DEF) res.scrolled = advance_line();
          end
        end
        MODE_CLEAR: begin
          blank_cells(0);
          row = 0;
          col = 0;
        end
        MODE_READ: begin
          if (idx < CELL_COUNT) res.cell_word = cells[idx];
        end
        default: ;
      endcase
      res.cursor_row = row[4:0];
      res.cursor_col = col[6:0];
      pending.push_back(res);
    endfunction

    function void check_result(logic [31:0] data);
      console_result_t got;
      console_result_t want;
      got = data[28:0];
      if (pending.size() == 0) begin
        $display("%0t: unexpected result transaction, actual %h", $time, data);
        error_count++;
        return;
      end
      want = pending.pop_front();
      if (got.cell_word !== want.cell_word) begin
        $display("%0t: cell_word mismatch, expected %h actual %h",
                 $time, want.cell_word, got.cell_word);
        error_count++;
      end
      if (got.cursor_row !== want.cursor_row) begin
        $display("%0t: cursor_row mismatch, expected %0d actual %0d",
                 $time, want.cursor_row, got.cursor_row);
        error_count++;
      end
      if (got.cursor_col !== want.cursor_col) begin
        $display("%0t: cursor_col mismatch, expected %0d actual %0d",
                 $time, want.cursor_col, got.cursor_col);
        error_count++;
      end
      if (got.scrolled !== want.scrolled) begin
        $display("%0t: scrolled mismatch, expected %0b actual %0b",
                 $time, want.scrolled, got.scrolled);
        error_count++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [7:0] char_code, [18:8] cell_index
  logic [1:0]  s_axis_tuser;   // [1:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [15:0] cell_word, [20:16] row, [27:21] col, [28] scrolled
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  console_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  longint cycle_count = 0;

  text_console_writer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random backpressure, changed at the falling edge
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task send_command(input logic [1:0] mode, input logic [7:0] ch, input logic [10:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = mode;
    s_axis_tdata = {5'b0, idx, ch};
    do begin
      @(posedge clk);
    end while (!s_axis_tready);
    sb.note_command(mode, ch, idx);
    @(negedge clk);
  endtask

  task wait_for_results_drained();
    s_axis_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task write_attribute(input logic [7:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_TEXT_ATTRIBUTE;
    pwdata = {24'b0, value};
    @(negedge clk);
    penable = 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    sb.set_attribute(value);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic logic [10:0] pick_read_index();
    int unsigned r;
    int unsigned pos;
    int unsigned back;
    r = $urandom_range(99);
    if (r < 40) begin
      // near the cursor, where text was just written
      pos = sb.row * COLUMNS_DEF + sb.col;
      back = $urandom_range(1, 160);
      return (pos >= back) ? 11'(pos - back) : 11'd0;
    end else if (r < 85) begin
      return 11'($urandom_range(CELL_COUNT - 1));
    end
    return 11'($urandom_range(CELL_COUNT, 2047));
  endfunction

  task run_random_traffic(input int unsigned target);
    int unsigned sent;
    int unsigned kind;
    int unsigned r;
    logic [7:0]  ch;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        // text run with some line breaks and corrections
        repeat ($urandom_range(1, 120)) begin
          if (sent < target) begin
            r = $urandom_range(99);
            if (r < 8) ch = CH_NEWLINE;
            else if (r < 13) ch = CH_BACKSPACE;
            else ch = 8'($urandom_range(255));
            send_command(MODE_PUT, ch, 11'($urandom_range(2047)));
            sent++;
          end
        end
      end else if (kind < 60) begin
        repeat ($urandom_range(1, 30)) begin
          if (sent < target) begin
            send_command(MODE_PUT, CH_NEWLINE, 11'($urandom_range(2047)));
            sent++;
          end
        end
      end else if (kind < 70) begin
        repeat ($urandom_range(1, 90)) begin
          if (sent < target) begin
            send_command(MODE_PUT, CH_BACKSPACE, 11'($urandom_range(2047)));
            sent++;
          end
        end
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 6)) begin
          if (sent < target) begin
            send_command(MODE_READ, 8'($urandom_range(255)), pick_read_index());
            sent++;
          end
        end
      end else if (kind < 94) begin
        send_command(MODE_CLEAR, 8'($urandom_range(255)), 11'($urandom_range(2047)));
        sent++;
      end else begin
        send_command(MODE_UNUSED, 8'($urandom_range(255)), 11'($urandom_range(2047)));
        sent++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = MODE_PUT;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: nothing here reads a cell before the first clear
    send_command(MODE_PUT, CH_BACKSPACE, 11'd0);      // backspace at home
    send_command(MODE_UNUSED, 8'hFF, 11'd2047);
    send_command(MODE_READ, 8'h00, 11'd2047);         // out of range
    send_command(MODE_READ, 8'h00, 11'(CELL_COUNT));
    send_command(MODE_PUT, 8'h41, 11'd0);
    send_command(MODE_CLEAR, 8'h00, 11'd0);
    send_command(MODE_READ, 8'h00, 11'd0);
    send_command(MODE_READ, 8'h00, 11'(CELL_COUNT - 1));
    send_command(MODE_PUT, 8'h00, 11'd0);
    send_command(MODE_PUT, 8'hFF, 11'd0);
    send_command(MODE_PUT, 8'h80, 11'd0);              // high bit set, still printed
    send_command(MODE_READ, 8'h00, 11'd0);
    send_command(MODE_READ, 8'h00, 11'd1);
    send_command(MODE_READ, 8'h00, 11'd2);
    send_command(MODE_PUT, CH_NEWLINE, 11'd0);
    send_command(MODE_PUT, CH_BACKSPACE, 11'd0);      // back across the line start
    send_command(MODE_PUT, 8'h7E, 11'd0);              // last column, wraps
    send_command(MODE_READ, 8'h00, 11'(COLUMNS_DEF - 1));
    send_command(MODE_PUT, CH_BACKSPACE, 11'd0);
    wait_for_results_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  write_attribute(8'h00); end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  write_attribute(8'hFF); end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61;
                 write_attribute(8'($urandom_range(1, 254))); end
        default: begin send_idle_pct = 28; recv_stall_pct = 28;
                 write_attribute(8'($urandom_range(255))); end
      endcase
      run_random_traffic(RANDOM_PER_PHASE / 2);
      wait_for_results_drained();   // sender holds off until all results are back
      run_random_traffic(RANDOM_PER_PHASE / 2);
      wait_for_results_drained();
    end

    recv_stall_pct = 0;
    repeat (20) @(posedge clk);
    if (sb.error_count == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/tcw_pkg.sv
rtl/tcw_screen_ram.sv
rtl/text_console_writer.sv
verif/tb.sv
